// File: hw/rtl/sidp_pkg.sv
// Shared types and constants for the stream ID text parser.
// Used by the core, parser and digit RTL files; depends on nothing else.
package sidp_pkg;

  localparam int unsigned ValW = 64;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Command codes, sampled with the first byte of a text.
  typedef enum logic [1:0] {
    CMD_PLAIN  = 2'd0,
    CMD_STRICT = 2'd1,
    CMD_WILD   = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MS   = 2'd1,
    PH_SEQ  = 2'd2
  } phase_e;

  // Position inside one decimal part.
  typedef enum logic [1:0] {
    SUB_LEAD   = 2'd0,
    SUB_SIGNED = 2'd1,
    SUB_DIGITS = 2'd2,
    SUB_JUNK   = 2'd3
  } sub_e;

  typedef struct packed {
    logic            id_valid;
    logic [ValW-1:0] ms_value;
    logic [ValW-1:0] seq_value;
    logic            seq_explicit;
    logic            exclusive_bound;
  } res_t;

endpackage

// File: hw/rtl/sidp_in_if.sv
// Input channel of the stream ID text parser: one text byte per transaction.
// Depends on nothing else.
interface sidp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        last_byte;
  logic [63:0] dflt_seq;
  logic [1:0]  cmd;

  modport source (output valid, text_byte, last_byte, dflt_seq, cmd, input ready);
  modport sink   (input valid, text_byte, last_byte, dflt_seq, cmd, output ready);
endinterface

// File: hw/rtl/sidp_out_if.sv
// Output channel of the stream ID text parser: one parsed ID per transaction.
// Depends on nothing else.
interface sidp_out_if;
  logic        valid;
  logic        ready;
  logic        id_valid;
  logic [63:0] ms_value;
  logic [63:0] seq_value;
  logic        seq_explicit;
  logic        exclusive_bound;

  modport source (output valid, id_valid, ms_value, seq_value, seq_explicit, exclusive_bound,
                  input ready);
  modport sink   (input valid, id_valid, ms_value, seq_value, seq_explicit, exclusive_bound,
                  output ready);
endinterface

// File: hw/rtl/stream_id_text_parser_core.sv
// Top level of the stream ID text parser: input register, parser, result register.
// Depends on sidp_pkg, sidp_in_if, sidp_out_if and sidp_parser.

// The parser takes an ID text one byte per transaction on in_i and returns one
// transaction on out_o for every byte marked last_byte, carrying the parsed
// (ms, seq) pair and its flags. It sustains one byte per clock cycle but for
// the stall below: a byte is captured in the input register and from there
// updates the parse state, where the per-byte times-ten accumulate of a 64-bit
// part with its overflow check is the step that sets the cycle time. The result
// of a text is registered as its last byte leaves the input register. The block
// keeps accepting bytes of the next text while a result waits on out_o; only a
// second last byte stalls until the waiting result is taken. The cmd and
// dflt_seq fields are sampled with the first byte of each text and ignored
// on the others. MAX_TEXT_LEN is the longest text accepted as valid, counted
// in bytes without a leading exclusive-bound parenthesis.
module stream_id_text_parser_core #(
  parameter int unsigned MAX_TEXT_LEN = 127
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sidp_in_if.sink    in_i,
  sidp_out_if.source out_o
);

  // Input register.
  logic                      in_vld_q;
  logic [7:0]                byte_q;
  logic                      last_q;
  logic [sidp_pkg::ValW-1:0] miss_q;
  logic [1:0]                cmd_q;

  // Result register.
  logic                      out_vld_q;
  sidp_pkg::res_t            res_q;
  sidp_pkg::res_t            res_d;

  logic                      step;

  // A buffered byte moves on unless it ends a text while the result register
  // still holds an untaken result.
  assign step       = in_vld_q && (!last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.text_byte;
      last_q <= in_i.last_byte;
      miss_q <= in_i.dflt_seq;
      cmd_q  <= in_i.cmd;
    end
  end

  sidp_parser #(
    .MaxTextLen (MAX_TEXT_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (byte_q),
    .last_byte_i (last_q),
    .dflt_seq_i  (miss_q),
    .cmd_i       (cmd_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.id_valid        = res_q.id_valid;
  assign out_o.ms_value        = res_q.ms_value;
  assign out_o.seq_value       = res_q.seq_value;
  assign out_o.seq_explicit    = res_q.seq_explicit;
  assign out_o.exclusive_bound = res_q.exclusive_bound;

endmodule

// File: hw/rtl/sidp_digit.sv
// Times-ten digit accumulate with overflow detect, plus the negated twin value.
// Depends on sidp_pkg.
module sidp_digit (
  input  logic [sidp_pkg::ValW-1:0] acc_i,
  input  logic [sidp_pkg::ValW-1:0] nacc_i,
  input  logic [3:0]                digit_i,
  output logic [sidp_pkg::ValW-1:0] sum_o,
  output logic [sidp_pkg::ValW-1:0] nsum_o,
  output logic                      ovf_o
);

  localparam int unsigned WideW = sidp_pkg::ValW + 4;

  logic [WideW-1:0] wide;

  assign wide   = ({4'b0, acc_i} << 3) + ({4'b0, acc_i} << 1) + WideW'(digit_i);
  assign sum_o  = wide[sidp_pkg::ValW-1:0];
  assign ovf_o  = |wide[WideW-1:sidp_pkg::ValW];
  // Tracks the two's complement of the accumulator, so a negative part needs
  // no subtraction at the end of the text.
  assign nsum_o = (nacc_i << 3) + (nacc_i << 1) - sidp_pkg::ValW'(digit_i);

endmodule

// File: hw/rtl/sidp_parser.sv
// Per-byte parse state and end-of-text decision for the stream ID parser.
// Depends on sidp_pkg and sidp_digit.
module sidp_parser #(
  parameter int unsigned MaxTextLen = 127
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                text_byte_i,
  input  logic                      last_byte_i,
  input  logic [sidp_pkg::ValW-1:0] dflt_seq_i,
  input  logic [1:0]                cmd_i,
  output sidp_pkg::res_t            res_o
);

  localparam int unsigned CntW = $clog2(MaxTextLen + 3);
  localparam logic [CntW-1:0] CntCap = CntW'(MaxTextLen + 2);
  localparam logic [CntW-1:0] LenMax = CntW'(MaxTextLen);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);

  sidp_pkg::phase_e          phase_q, c_phase, phase_d;
  sidp_pkg::sub_e            sub_q, c_sub, sub_d;
  sidp_pkg::cmd_e            mode_q, c_mode;
  logic [CntW-1:0]           cnt_q, c_cnt, cnt_d, eff_len;
  logic [sidp_pkg::ValW-1:0] ms_q, c_ms, ms_d;
  logic [sidp_pkg::ValW-1:0] seq_q, c_seq, seq_d;
  logic [sidp_pkg::ValW-1:0] nseq_q, c_nseq, nseq_d;
  logic [sidp_pkg::ValW-1:0] miss_q, c_miss;
  logic                      neg_q, c_neg, neg_d;
  logic                      ovf_q, c_ovf, ovf_d;
  logic                      msok_q, c_msok, msok_d;
  logic                      ended_q, c_ended, ended_d;
  logic                      paren_q, c_paren, paren_d;
  logic                      excl_q, c_excl, excl_d;
  logic [1:0]                tlen_q, c_tlen, tlen_d;
  logic [1:0]                slen_q, c_slen, slen_d;
  logic [7:0]                fc_q, c_fc, fc_d;
  logic [7:0]                sf_q, c_sf, sf_d;

  logic [sidp_pkg::ValW-1:0] acc_sel, d_sum, d_nsum;
  logic                      d_ovf;
  logic                      is_dig, is_sp, add_dig, strict, wild, part_ok;
  sidp_pkg::sub_e            feed_sub;

  assign acc_sel = (c_phase == sidp_pkg::PH_SEQ) ? c_seq : c_ms;

  sidp_digit u_digit (
    .acc_i   (acc_sel),
    .nacc_i  (c_nseq),
    .digit_i (text_byte_i[3:0]),
    .sum_o   (d_sum),
    .nsum_o  (d_nsum),
    .ovf_o   (d_ovf)
  );

  always_comb begin
    // The first byte of a text sees a freshly cleared state.
    if (phase_q == sidp_pkg::PH_IDLE) begin
      c_phase = sidp_pkg::PH_MS;
      c_mode  = sidp_pkg::cmd_e'(cmd_i);
      c_miss  = dflt_seq_i;
      c_cnt   = '0;
      c_ms    = '0;
      c_seq   = '0;
      c_nseq  = '0;
      c_sub   = sidp_pkg::SUB_LEAD;
      c_neg   = 1'b0;
      c_ovf   = 1'b0;
      c_msok  = 1'b0;
      c_ended = 1'b0;
      c_paren = 1'b0;
      c_excl  = 1'b0;
      c_tlen  = '0;
      c_slen  = '0;
      c_fc    = '0;
      c_sf    = '0;
    end else begin
      c_phase = phase_q;
      c_mode  = mode_q;
      c_miss  = miss_q;
      c_cnt   = cnt_q;
      c_ms    = ms_q;
      c_seq   = seq_q;
      c_nseq  = nseq_q;
      c_sub   = sub_q;
      c_neg   = neg_q;
      c_ovf   = ovf_q;
      c_msok  = msok_q;
      c_ended = ended_q;
      c_paren = paren_q;
      c_excl  = excl_q;
      c_tlen  = tlen_q;
      c_slen  = slen_q;
      c_fc    = fc_q;
      c_sf    = sf_q;
    end

    phase_d = c_phase;
    ms_d    = c_ms;
    seq_d   = c_seq;
    nseq_d  = c_nseq;
    sub_d   = c_sub;
    neg_d   = c_neg;
    ovf_d   = c_ovf;
    msok_d  = c_msok;
    ended_d = c_ended;
    paren_d = c_paren;
    excl_d  = c_excl;
    tlen_d  = c_tlen;
    slen_d  = c_slen;
    fc_d    = c_fc;
    sf_d    = c_sf;
    cnt_d   = (c_cnt < CntCap) ? c_cnt + CntOne : c_cnt;

    is_dig   = (text_byte_i >= sidp_pkg::CH_ZERO) && (text_byte_i <= sidp_pkg::CH_NINE);
    is_sp    = (text_byte_i == sidp_pkg::CH_SPACE) ||
               ((text_byte_i >= sidp_pkg::CH_TAB) && (text_byte_i <= sidp_pkg::CH_CR));
    add_dig  = 1'b0;
    feed_sub = sidp_pkg::SUB_JUNK;

    if ((c_mode == sidp_pkg::CMD_RANGE) && (cnt_d == CntOne) &&
        (text_byte_i == sidp_pkg::CH_LPAREN)) begin
      paren_d = 1'b1;
    end else begin
      if (c_paren && (cnt_d == CntTwo)) begin
        excl_d = 1'b1;
      end
      if (!c_ended) begin
        if (text_byte_i == sidp_pkg::CH_NUL) begin
          ended_d = 1'b1;
        end else begin
          if (c_tlen < 2'd2) begin
            tlen_d = c_tlen + 2'd1;
          end
          if (tlen_d == 2'd1) begin
            fc_d = text_byte_i;
          end
          if ((c_phase == sidp_pkg::PH_MS) && (text_byte_i == sidp_pkg::CH_DASH)) begin
            // The first dash closes the ms part and opens the seq part.
            msok_d  = (c_sub == sidp_pkg::SUB_DIGITS) && !c_ovf;
            sub_d   = sidp_pkg::SUB_LEAD;
            neg_d   = 1'b0;
            ovf_d   = 1'b0;
            phase_d = sidp_pkg::PH_SEQ;
          end else begin
            if (c_phase == sidp_pkg::PH_SEQ) begin
              if (c_slen < 2'd2) begin
                slen_d = c_slen + 2'd1;
              end
              if (slen_d == 2'd1) begin
                sf_d = text_byte_i;
              end
            end
            case (c_sub) inside
              sidp_pkg::SUB_LEAD: begin
                if (is_sp) begin
                  feed_sub = sidp_pkg::SUB_LEAD;
                end else if (text_byte_i == sidp_pkg::CH_PLUS) begin
                  feed_sub = sidp_pkg::SUB_SIGNED;
                end else if (text_byte_i == sidp_pkg::CH_DASH) begin
                  feed_sub = sidp_pkg::SUB_SIGNED;
                  neg_d    = 1'b1;
                end else if (is_dig) begin
                  feed_sub = sidp_pkg::SUB_DIGITS;
                  add_dig  = 1'b1;
                end
              end
              sidp_pkg::SUB_SIGNED, sidp_pkg::SUB_DIGITS: begin
                if (is_dig) begin
                  feed_sub = sidp_pkg::SUB_DIGITS;
                  add_dig  = 1'b1;
                end
              end
              default: begin
              end
            endcase
            sub_d = feed_sub;
            if (add_dig && !c_ovf) begin
              if (d_ovf) begin
                ovf_d = 1'b1;
              end else if (c_phase == sidp_pkg::PH_SEQ) begin
                seq_d  = d_sum;
                nseq_d = d_nsum;
              end else begin
                ms_d = d_sum;
              end
            end
          end
        end
      end
    end

    // End-of-text decision, valid only when the byte is the last one.
    strict  = (c_mode == sidp_pkg::CMD_STRICT) || (c_mode == sidp_pkg::CMD_WILD) || excl_d;
    wild    = (c_mode == sidp_pkg::CMD_WILD);
    eff_len = cnt_d - CntW'(excl_d);
    part_ok = (sub_d == sidp_pkg::SUB_DIGITS) && !ovf_d;

    res_o                 = '0;
    res_o.exclusive_bound = excl_d;
    if ((eff_len > LenMax) || (paren_d && !excl_d)) begin
      res_o.id_valid = 1'b0;
    end else if ((tlen_d == 2'd1) &&
                 ((fc_d == sidp_pkg::CH_DASH) || (fc_d == sidp_pkg::CH_PLUS))) begin
      if (!strict) begin
        res_o.id_valid     = 1'b1;
        res_o.seq_explicit = 1'b1;
        if (fc_d == sidp_pkg::CH_PLUS) begin
          res_o.ms_value  = '1;
          res_o.seq_value = '1;
        end
      end
    end else if (phase_d == sidp_pkg::PH_MS) begin
      if (part_ok) begin
        res_o.id_valid     = 1'b1;
        res_o.seq_explicit = 1'b1;
        res_o.ms_value     = ms_d;
        res_o.seq_value    = c_miss;
      end
    end else if (msok_d) begin
      if (wild && (slen_d == 2'd1) && (sf_d == sidp_pkg::CH_STAR)) begin
        res_o.id_valid = 1'b1;
        res_o.ms_value = ms_d;
      end else if (part_ok) begin
        res_o.id_valid     = 1'b1;
        res_o.seq_explicit = 1'b1;
        res_o.ms_value     = ms_d;
        res_o.seq_value    = neg_d ? nseq_d : seq_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sidp_pkg::PH_IDLE;
      mode_q  <= sidp_pkg::CMD_PLAIN;
      sub_q   <= sidp_pkg::SUB_LEAD;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      msok_q  <= 1'b0;
      ended_q <= 1'b0;
      paren_q <= 1'b0;
      excl_q  <= 1'b0;
      tlen_q  <= '0;
      slen_q  <= '0;
    end else if (step_i) begin
      phase_q <= last_byte_i ? sidp_pkg::PH_IDLE : phase_d;
      mode_q  <= c_mode;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      msok_q  <= msok_d;
      ended_q <= ended_d;
      paren_q <= paren_d;
      excl_q  <= excl_d;
      tlen_q  <= tlen_d;
      slen_q  <= slen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      ms_q   <= ms_d;
      seq_q  <= seq_d;
      nseq_q <= nseq_d;
      miss_q <= c_miss;
      fc_q   <= fc_d;
      sf_q   <= sf_d;
    end
  end

endmodule
